@@ design/utd_pkg.sv @@
// Package for the UTF-8 to code point decoder.
// Holds widths, the substitute code, the result group type and a lead helper.
// No dependencies.
`timescale 1ns / 1ps

package utd_pkg;

  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] SUBST_CP = 21'd63;

  // Results caused by one input byte: some '?' beats, then an optional tail beat.
  typedef struct packed {
    logic [1:0]      subs;      // leading '?' beats
    logic            has_tail;
    logic [CP_W-1:0] tail_cp;
    logic            tail_rep;
    logic            fin;       // final_char on the last beat of the group
  } grp_t;

  // Continuation bytes a lead byte asks for.
  function automatic logic [1:0] cont_need(input logic [7:0] lead);
    logic [1:0] n;
    n = 2'd3;
    if (lead[7:5] == 3'b110) begin
      n = 2'd1;
    end else if (lead[7:4] == 4'b1110) begin
      n = 2'd2;
    end
    return n;
  endfunction

endpackage

@@ design/utf8_to_code_point_decoder.sv @@
// Top level of the UTF-8 to code point decoder.
// Instantiates utd_decode and utd_emit; depends on utd_pkg.
//
//  channel  dir  tdata                      tuser      tlast
//  in_      in   [7:0] data_byte            -          end_of_text
//  out_     out  [20:0] code_point, 0-pad   replaced   final_char
//
// One byte is accepted per cycle while in_tready is high; its result group is
// registered, then moved to the output register and sent one beat per cycle while out_tready is high.
// A byte causing several results holds the input until its group's last beat is taken
// once the one-group buffer ahead of the output is full.
// Reset clears the held sequence and drops any queued results.
`timescale 1ns / 1ps

module utf8_to_code_point_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tuser,  // [0] replaced
  output logic        out_tlast
);
  import utd_pkg::*;

  grp_t grp;
  logic grp_valid;
  logic grp_ready;

  utd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  utd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready),
    .grp        (grp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ design/utd_decode.sv @@
// Byte decoder: sequence state plus a registered result group per input beat that yields results.
// Depends on utd_pkg.
`timescale 1ns / 1ps

module utd_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          grp_valid,
  input  logic          grp_ready,
  output utd_pkg::grp_t grp
);
  import utd_pkg::*;

  logic [7:0]  held_lead_r, held_lead_nxt;
  logic [1:0]  held_count_r, held_count_nxt;
  logic [17:0] held_bits_r, held_bits_nxt;
  logic        lead_valid_r, lead_valid_nxt;
  logic        s1_valid_r;
  grp_t        s1_grp_r;

  grp_t        dec;
  logic        accept;
  logic        is_cont;
  logic        is_lead;
  logic [1:0]  need;
  logic [2:0]  cnt;
  logic [17:0] bits;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !s1_valid_r || grp_ready;
  assign grp_valid = s1_valid_r;
  assign grp       = s1_grp_r;

  assign is_cont = in_tdata[7:6] == 2'b10;
  assign is_lead = (in_tdata[7:6] == 2'b11) && (in_tdata[7:3] != 5'b11111);
  assign need    = cont_need(held_lead_r);
  assign cnt     = {1'b0, held_count_r} + 3'd1;
  assign bits    = {held_bits_r[11:0], in_tdata[5:0]};

  always_comb begin
    dec            = '0;
    dec.fin        = in_tlast;
    held_lead_nxt  = held_lead_r;
    held_count_nxt = held_count_r;
    held_bits_nxt  = held_bits_r;
    lead_valid_nxt = lead_valid_r;
    if (lead_valid_r && is_cont) begin
      if (cnt == {1'b0, need}) begin
        dec.has_tail = 1'b1;
        unique case (need)
          2'd1:    dec.tail_cp = {10'd0, held_lead_r[4:0], bits[5:0]};
          2'd2:    dec.tail_cp = {5'd0, held_lead_r[3:0], bits[11:0]};
          default: dec.tail_cp = {held_lead_r[2:0], bits};
        endcase
        lead_valid_nxt = 1'b0;
        held_count_nxt = 2'd0;
      end else if (in_tlast) begin
        // stream ends mid-sequence: '?' for lead, held bytes and this byte
        dec.subs       = held_count_r + 2'd1;
        dec.has_tail   = 1'b1;
        dec.tail_cp    = SUBST_CP;
        dec.tail_rep   = 1'b1;
        lead_valid_nxt = 1'b0;
        held_count_nxt = 2'd0;
      end else begin
        held_count_nxt = cnt[1:0];
        held_bits_nxt  = bits;
      end
    end else begin
      // a held lead is broken by this byte; flush it, then take the byte afresh
      if (lead_valid_r) begin
        dec.subs = held_count_r + 2'd1;
      end
      lead_valid_nxt = 1'b0;
      held_count_nxt = 2'd0;
      if (!in_tdata[7]) begin
        dec.has_tail = 1'b1;
        dec.tail_cp  = {13'd0, in_tdata};
      end else if (is_lead && !in_tlast) begin
        held_lead_nxt  = in_tdata;
        held_bits_nxt  = '0;
        lead_valid_nxt = 1'b1;
      end else begin
        dec.has_tail = 1'b1;
        dec.tail_cp  = SUBST_CP;
        dec.tail_rep = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_valid_r <= 1'b0;
      held_count_r <= 2'd0;
      held_lead_r  <= 8'd0;
      held_bits_r  <= 18'd0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        lead_valid_r <= lead_valid_nxt;
        held_count_r <= held_count_nxt;
        held_lead_r  <= held_lead_nxt;
        held_bits_r  <= held_bits_nxt;
        s1_valid_r   <= (dec.subs != 2'd0) || dec.has_tail;
      end else if (grp_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_grp_r <= dec;
    end
  end

  a_count_below_need: assert property (@(posedge clk) disable iff (!rst_n)
    lead_valid_r |-> held_count_r < cont_need(held_lead_r))
    else $error("held count reached the sequence length");

  a_end_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> !lead_valid_r)
    else $error("lead still held after last byte");

  a_group_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_grp_r.subs != 2'd0) || s1_grp_r.has_tail)
    else $error("empty result group queued");

endmodule

@@ design/utd_emit.sv @@
// Result serializer: expands one result group into output beats.
// Depends on utd_pkg.
`timescale 1ns / 1ps

module utd_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          grp_valid,
  output logic          grp_ready,
  input  utd_pkg::grp_t grp,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [23:0]   out_tdata,
  output logic          out_tuser,
  output logic          out_tlast
);
  import utd_pkg::*;

  grp_t       cur_r;
  logic       busy;
  logic       beat_last;
  logic       take;
  logic [CP_W-1:0] cp;

  assign busy      = (cur_r.subs != 2'd0) || cur_r.has_tail;
  assign beat_last = (cur_r.subs == 2'd1 && !cur_r.has_tail) ||
                     (cur_r.subs == 2'd0 && cur_r.has_tail);
  assign take      = out_tvalid && out_tready;
  assign grp_ready = !busy || (take && beat_last);

  assign out_tvalid = busy;
  assign cp         = (cur_r.subs != 2'd0) ? SUBST_CP : cur_r.tail_cp;
  assign out_tdata  = {3'd0, cp};
  assign out_tuser  = (cur_r.subs != 2'd0) || cur_r.tail_rep;
  assign out_tlast  = cur_r.fin && beat_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      if (grp_ready) begin
        if (grp_valid) begin
          cur_r <= grp;
        end else begin
          cur_r.subs     <= 2'd0;
          cur_r.has_tail <= 1'b0;
        end
      end else if (take) begin
        cur_r.subs <= cur_r.subs - 2'd1;
      end
    end
  end

  a_subst_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[CP_W-1:0] == SUBST_CP)
    else $error("replaced beat without substitute code");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    take && !beat_last |=> out_tvalid)
    else $error("group dropped before its last beat");

  a_last_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> beat_last)
    else $error("tlast on an inner beat");

endmodule
